[hw/rtl/ofc_pkg.sv]
// ----------------------------------------------------------------------------
// ofc_pkg
// Shared types and constants for the ordered factorization counter.
// ----------------------------------------------------------------------------
package ofc_pkg;

  localparam int          OFC_VALUE_BITS  = 21;
  localparam int          OFC_PRIME_SLOTS = 256;
  localparam int          FIELD_W         = 30;
  localparam logic [29:0] MODULUS         = 30'd1000000007;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQUARE,
    ST_DIV,
    ST_DIV_CHK,
    ST_BIN_MUL,
    ST_ACC_MUL,
    ST_NEXT,
    ST_END,
    ST_LEFT_MUL,
    ST_FINISH
  } state_t;

endpackage

[hw/rtl/ordered_factorization_count_top.sv]
// ----------------------------------------------------------------------------
// ordered_factorization_count_top
// Counts ordered m-tuples with product n, modulo 1000000007, by trial
// division over a prime ROM and a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | n_value, tuple_count
//  out_    | output    | out_valid/stall  | tuple_total
//
//  Work per item: each tried prime passes through fetch, square, the divider
//  and a step; the divider runs e+1 times. Each modular multiply is bit-serial,
//  e+1 of them for a prime that divides n and one for a leftover factor. The
//  one-bit restoring divider walking the prime ROM dominates; the worst case is
//  a large prime n that tries every prime in the ROM at 21 bits.
//  Reset (rst_n low, synchronous) returns the controller to idle and empties
//  the output register. One item is worked on at a time; in_stall is high
//  while busy. A finished result waits in the output register under out_stall.
// ----------------------------------------------------------------------------
module ordered_factorization_count_top
  import ofc_pkg::*;
#(
  parameter int VALUE_BITS  = OFC_VALUE_BITS,
  parameter int PRIME_SLOTS = OFC_PRIME_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_n_value,
  input  logic [29:0]           in_tuple_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [29:0]           out_tuple_total
);

  localparam int PW = (VALUE_BITS + 1) / 2;          // prime width
  localparam int AW = $clog2(PRIME_SLOTS);           // ROM address
  localparam int IW = AW + 1;                        // index, holds total
  localparam int ID = VALUE_BITS + 1;                // inv factorial depth
  localparam int EW = $clog2(ID);                    // exponent width
  localparam int CW = $clog2(VALUE_BITS);            // divider step count

  typedef logic [PW-1:0] prime_arr_t [PRIME_SLOTS];
  typedef logic [29:0]   invf_arr_t  [ID];

  // Elaboration-time remainder, shift and subtract over 63 bits.
  function automatic longint cmod(longint a, longint b);
    longint r;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | longint'(a[i]);
      if (r >= b) r = r - b;
    end
    return r;
  endfunction

  // Elaboration-time prime list: all p with p*p <= 2^VALUE_BITS - 1.
  function automatic prime_arr_t gen_primes();
    prime_arr_t   tab;
    longint       maxv;
    longint       c;
    int           cnt;
    bit           isp;
    maxv = (longint'(1) << VALUE_BITS) - 1;
    cnt  = 0;
    for (int k = 0; k < PRIME_SLOTS; k++) tab[k] = '0;
    for (c = 2; c * c <= maxv && cnt < PRIME_SLOTS; c++) begin
      isp = 1'b1;
      for (int j = 0; j < cnt; j++) begin
        if (longint'(tab[j]) * longint'(tab[j]) > c) break;
        if (cmod(c, longint'(tab[j])) == 0) begin
          isp = 1'b0;
          break;
        end
      end
      if (isp) begin
        tab[cnt] = PW'(c);
        cnt++;
      end
    end
    return tab;
  endfunction

  function automatic int count_primes();
    prime_arr_t tab;
    int         cnt;
    tab = gen_primes();
    cnt = 0;
    for (int k = 0; k < PRIME_SLOTS; k++) if (tab[k] != '0) cnt++;
    return cnt;
  endfunction

  function automatic longint mmul(longint a, longint b);
    return cmod(a * b, longint'(MODULUS));
  endfunction

  function automatic invf_arr_t gen_invf();
    invf_arr_t tab;
    longint    f;
    longint    r;
    longint    b;
    longint    x;
    f = 1;
    for (int k = 0; k < ID; k++) begin
      if (k > 0) f = mmul(f, longint'(k));
      r = 1;
      b = f;
      x = longint'(MODULUS) - 2;
      while (x != 0) begin
        if (x[0]) r = mmul(r, b);
        b = mmul(b, b);
        x = x >> 1;
      end
      tab[k] = 30'(r);
    end
    return tab;
  endfunction

  localparam prime_arr_t PRIME_TAB = gen_primes();
  localparam invf_arr_t  INVF_TAB  = gen_invf();
  localparam logic [IW-1:0] PTOTAL = IW'(count_primes());

  state_t                  state_r, state_nxt;
  logic [VALUE_BITS-1:0]   r_r, r_nxt;           // remaining value
  logic [29:0]             m_r, m_nxt;
  logic [29:0]             acc_r, acc_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [EW-1:0]           e_r, e_nxt;
  logic [EW-1:0]           k_r, k_nxt;
  logic [PW-1:0]           prime_q_r;            // ROM read data
  logic [2*PW-1:0]         psq_r, psq_nxt;
  logic [PW-1:0]           rem_r, rem_nxt;
  logic [VALUE_BITS-1:0]   dq_r, dq_nxt;
  logic [CW-1:0]           dcnt_r, dcnt_nxt;
  logic [29:0]             ma_r, ma_nxt;         // multiplicand
  logic [29:0]             mb_r, mb_nxt;         // multiplier, MSB first
  logic [29:0]             mp_r, mp_nxt;         // partial product
  logic [4:0]              mcnt_r, mcnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [29:0]             out_total_r, out_total_nxt;

  // datapath helpers
  logic [PW:0]             div_t;
  logic                    div_ge;
  logic [31:0]             mul_t;
  logic [31:0]             mul_t1;
  logic [29:0]             mul_res;
  logic                    mul_last;
  logic                    div_last;
  logic [30:0]             top_w;
  logic [IW-1:0]           idx_inc;
  logic                    r_lt_psq;             // remainder below p*p
  logic                    in_acc;

  assign in_stall        = (state_r != ST_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_tuple_total = out_total_r;

  // prime ROM, registered read
  always_ff @(posedge clk) begin
    prime_q_r <= PRIME_TAB[idx_r[AW-1:0]];
  end

  always_comb begin
    div_t    = {rem_r, dq_r[VALUE_BITS-1]};
    div_ge   = div_t >= {1'b0, prime_q_r};
    div_last = (dcnt_r == CW'(VALUE_BITS - 1));
    mul_t    = {1'b0, mp_r, 1'b0} + (mb_r[29] ? {2'b00, ma_r} : 32'd0);
    mul_t1   = (mul_t >= {2'b00, MODULUS}) ? mul_t - {2'b00, MODULUS} : mul_t;
    mul_res  = (mul_t1 >= {2'b00, MODULUS}) ? 30'(mul_t1 - {2'b00, MODULUS})
                                            : 30'(mul_t1);
    mul_last = (mcnt_r == 5'd29);
    top_w    = {1'b0, m_r} + 31'(e_r) - 31'd1;
    idx_inc  = idx_r + IW'(1);
    r_lt_psq = (2*PW)'(r_r) < psq_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = (in_n_value <= VALUE_BITS'(1)) ? ST_FINISH
                                                                         : ST_FETCH;
      ST_FETCH:    state_nxt = ST_SQUARE;
      ST_SQUARE:   state_nxt = ST_DIV;
      ST_DIV:      if (div_last) state_nxt = ST_DIV_CHK;
      ST_DIV_CHK: begin
        if (rem_r == '0) state_nxt = ST_DIV;
        else if (e_r == '0) state_nxt = ST_NEXT;
        else if (top_w >= {1'b0, MODULUS}) state_nxt = ST_NEXT;
        else state_nxt = ST_BIN_MUL;
      end
      ST_BIN_MUL:  if (mul_last && (k_r + EW'(1) == e_r)) state_nxt = ST_ACC_MUL;
      ST_ACC_MUL:  if (mul_last) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (r_lt_psq)
          state_nxt = ST_END;
        else if (r_r > VALUE_BITS'(1) && idx_inc < PTOTAL) state_nxt = ST_FETCH;
        else state_nxt = ST_END;
      end
      ST_END:      state_nxt = (r_r > VALUE_BITS'(1)) ? ST_LEFT_MUL : ST_FINISH;
      ST_LEFT_MUL: if (mul_last) state_nxt = ST_FINISH;
      ST_FINISH:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    r_nxt         = r_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    psq_nxt       = psq_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    dcnt_nxt      = dcnt_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    mp_nxt        = mp_r;
    mcnt_nxt      = mcnt_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          r_nxt   = in_n_value;
          m_nxt   = in_tuple_count;
          acc_nxt = (in_n_value == '0) ? 30'd0 : 30'd1;
          idx_nxt = '0;
        end
      end
      ST_FETCH: e_nxt = '0;
      ST_SQUARE: begin
        psq_nxt  = (2*PW)'(prime_q_r) * (2*PW)'(prime_q_r);
        rem_nxt  = '0;
        dq_nxt   = r_r;
        dcnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? PW'(div_t - {1'b0, prime_q_r}) : PW'(div_t);
        dq_nxt   = {dq_r[VALUE_BITS-2:0], div_ge};
        dcnt_nxt = dcnt_r + CW'(1);
      end
      ST_DIV_CHK: begin
        if (rem_r == '0) begin
          // exact: take quotient, divide again
          r_nxt    = dq_r;
          e_nxt    = e_r + EW'(1);
          dcnt_nxt = '0;
        end else if (e_r != '0) begin
          if (top_w >= {1'b0, MODULUS}) begin
            acc_nxt = 30'd0;                 // binomial top at or above the modulus
          end else begin
            k_nxt    = '0;
            ma_nxt   = 30'(top_w);
            mb_nxt   = INVF_TAB[e_r];
            mp_nxt   = '0;
            mcnt_nxt = '0;
          end
        end
      end
      ST_BIN_MUL: begin
        mp_nxt   = mul_res;
        mb_nxt   = {mb_r[28:0], 1'b0};
        mcnt_nxt = mcnt_r + 5'd1;
        if (mul_last) begin
          k_nxt    = k_r + EW'(1);
          mcnt_nxt = '0;
          mp_nxt   = '0;
          if (k_r + EW'(1) == e_r) begin
            ma_nxt = acc_r;
            mb_nxt = mul_res;
          end else begin
            ma_nxt = 30'(top_w - 31'(k_r) - 31'd1);
            mb_nxt = mul_res;
          end
        end
      end
      ST_ACC_MUL: begin
        mp_nxt   = mul_res;
        mb_nxt   = {mb_r[28:0], 1'b0};
        mcnt_nxt = mcnt_r + 5'd1;
        if (mul_last) acc_nxt = mul_res;
      end
      ST_NEXT: begin
        if (!r_lt_psq)
          idx_nxt = idx_inc;
      end
      ST_END: begin
        // leftover prime contributes m mod 1000000007
        ma_nxt   = acc_r;
        mb_nxt   = (m_r >= MODULUS) ? m_r - MODULUS : m_r;
        mp_nxt   = '0;
        mcnt_nxt = '0;
      end
      ST_LEFT_MUL: begin
        mp_nxt   = mul_res;
        mb_nxt   = {mb_r[28:0], 1'b0};
        mcnt_nxt = mcnt_r + 5'd1;
        if (mul_last) acc_nxt = mul_res;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = acc_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      r_r         <= '0;
      acc_r       <= 30'd1;
      idx_r       <= '0;
      e_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      r_r         <= r_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
      e_r         <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r         <= m_nxt;
    k_r         <= k_nxt;
    psq_r       <= psq_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    dcnt_r      <= dcnt_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    mp_r        <= mp_nxt;
    mcnt_r      <= mcnt_nxt;
    out_total_r <= out_total_nxt;
  end

endmodule

[tb/tb_ordered_factorization_count_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_factorization_count_top
// Self-checking bench for the ordered factorization counter: directed table,
// then random queries under varied idling, checked against a local model.
// ----------------------------------------------------------------------------
module tb_ordered_factorization_count_top;
  import ofc_pkg::*;

  localparam int VB = OFC_VALUE_BITS;
  localparam longint unsigned MODV = 64'd1000000007;
  localparam int N_DIRECTED = 20;
  localparam longint CYCLE_LIMIT = 64'd8000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [VB-1:0] in_n_value;
  logic [29:0] in_tuple_count;
  logic out_valid;
  logic out_stall;
  logic [29:0] out_tuple_total;

  ordered_factorization_count_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_n_value(in_n_value), .in_tuple_count(in_tuple_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tuple_total(out_tuple_total)
  );

  // expected tuple totals, oldest first
  logic [29:0] total_q[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;   // sender idle percentage
  int recv_stall_pct = 0;  // receiver stall percentage
  bit hold_recv = 0;       // long receiver hold-off request

  // trial-division prime list and 1/k! table, built at time zero
  int unsigned primes[$];
  longint unsigned inv_fact[VB+1];

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
    return (a * b) % MODV;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned x);
    longint unsigned r;
    r = 1;
    while (x != 0) begin
      if (x[0]) r = mulmod(r, b);
      b = mulmod(b, b);
      x = x >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned binom_mod(longint unsigned m, int e);
    longint unsigned top;
    longint unsigned r;
    top = m + e - 1;
    if (top >= MODV || e > VB) return 0;
    r = inv_fact[e];
    for (int k = 0; k < e; k++) r = mulmod(r, top - k);
    return r;
  endfunction

  function automatic logic [29:0] count_tuples(logic [VB-1:0] n, logic [29:0] m);
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned p;
    int e;
    rem = n;
    acc = 1;
    if (n == 0) return 30'd0;
    foreach (primes[i]) begin
      if (rem <= 1) break;
      p = primes[i];
      e = 0;
      while (rem % p == 0) begin
        rem = rem / p;
        e++;
      end
      if (e > 0) acc = mulmod(acc, binom_mod(m, e));
      // remainder below p^2 must be prime
      if (rem < p * p) break;
    end
    if (rem > 1) acc = mulmod(acc, m % MODV);
    return acc[29:0];
  endfunction

  initial begin
    longint unsigned f;
    bit ok;
    f = 1;
    for (int c = 2; c * c <= (1 << VB) - 1 && primes.size() < OFC_PRIME_SLOTS; c++) begin
      ok = 1;
      foreach (primes[j]) begin
        if (primes[j] * primes[j] > c) break;
        if (c % primes[j] == 0) begin
          ok = 0;
          break;
        end
      end
      if (ok) primes.push_back(c);
    end
    for (int k = 0; k <= VB; k++) begin
      if (k > 0) f = mulmod(f, k);
      inv_fact[k] = powmod(f, MODV - 2);
    end
  end

  // directed table: expected is -1 where the predictor decides
  typedef struct {
    logic [VB-1:0] n;
    logic [29:0] m;
    longint want;
  } query_t;

  query_t directed[N_DIRECTED] = '{
    '{21'd1, 30'd5, 1},                       // n = 1
    '{21'd0, 30'd7, 0},                       // zero value
    '{21'd12, 30'd0, 0},                      // zero tuple length
    '{21'd1, 30'd0, 1},
    '{21'd2, 30'd3, 3},                       // single prime
    '{21'd8, 30'd2, 4},                       // 2^3, m=2
    '{21'd12, 30'd2, 6},
    '{21'h1FFFFF, 30'd1, 1},                  // max value, m=1
    '{21'h1FFFFF, 30'h3FFFFFFF, -1},          // max value, max m
    '{21'h100000, 30'd3, -1},                 // 2^20 high exponent
    '{21'd2097143, 30'd9, -1},                // large prime, leftover factor
    '{21'd1442897, 30'd4, -1},                // just above 1201 squared
    '{21'd30, 30'd1000000006, -1},
    '{21'd4, 30'd1000000006, 0},              // top reaches modulus
    '{21'd3, 30'd1000000007, 0},              // m mod modulus leftover
    '{21'd1000003, 30'h3FFFFFFF, -1},         // big m, leftover prime
    '{21'd1048575, 30'd123456789, -1},
    '{21'd510510, 30'd2, -1},                 // many small primes
    '{21'd1024, 30'd0, 0},
    '{21'h0AAAAA, 30'h15555555, -1}
  };

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall, plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (total_q.size() == 0) begin
        $error("tuple_total: unexpected item, actual %0d", out_tuple_total);
        errors++;
      end else begin
        if (out_tuple_total !== total_q[0]) begin
          $error("tuple_total: expected %0d actual %0d", total_q[0], out_tuple_total);
          errors++;
        end
        void'(total_q.pop_front());
      end
    end
  end

  // offer one item and wait until it is accepted; valid drops only when idling
  task automatic send_query(logic [VB-1:0] n, logic [29:0] m, longint want);
    logic [29:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_n_value <= n;
    in_tuple_count <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = count_tuples(n, m);
    if (want >= 0 && pred != want[29:0]) begin
      $error("tuple_total: table expects %0d, predictor %0d", want, pred);
      errors++;
    end
    total_q.push_back(want >= 0 ? want[29:0] : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (total_q.size() != 0) @(posedge clk);
  endtask

  // random query: small n or a scaled power of two, or full-range n
  task automatic random_query();
    logic [VB-1:0] n;
    logic [29:0] m;
    case ($urandom_range(3))
      0: n = VB'($urandom_range(64));
      1: n = VB'((1 << $urandom_range(VB - 1)) * $urandom_range(1, 3));
      default: n = VB'($urandom);
    endcase
    case ($urandom_range(3))
      0: m = 30'($urandom_range(5));
      1: m = 30'(30'd1000000000 + $urandom_range(73741823));
      default: m = 30'($urandom);
    endcase
    send_query(n, m, -1);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_n_value = '0;
    in_tuple_count = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_query(directed[i].n, directed[i].m, directed[i].want);
    // pause with nothing in flight
    drain();

    // long receiver hold-off while the sender keeps offering items
    fork
      begin
        hold_recv = 1;
        repeat (20000) @(posedge clk);
        hold_recv = 0;
      end
      repeat (4) random_query();
    join

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 66 : 22) : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3 ? 22 : 0);
      repeat (70) random_query();
    end
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
